/* rtl/ibsb_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ibsb_pkg;

    // defaults for the top level parameters
    localparam int DEF_MAX_ROWS   = 1024;
    localparam int DEF_MAX_FACTOR = 16;
    localparam int DEF_PIXEL_BITS = 32;

    // configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_BIN_FACTOR = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_ROWS = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_COLS = 2'd2;

    // register widths and reset values
    localparam int FACTOR_W = 5;
    localparam int ROWS_W   = 11;
    localparam int COLS_W   = 16;

    localparam logic [FACTOR_W-1:0] FACTOR_RST = 5'd2;
    localparam logic [ROWS_W-1:0]   ROWS_RST   = 11'd1024;
    localparam logic [COLS_W-1:0]   COLS_RST   = 16'd1024;

endpackage

`default_nettype wire

/* rtl/ibsb_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module ibsb_ram #(
    parameter int DATA_W = 40,
    parameter int DEPTH  = 1024
) (
    input  wire                                        aclk,
    input  wire                                        wr_en,
    input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire [DATA_W-1:0]                           wr_data,
    input  wire                                        rd_en,
    input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [DATA_W-1:0]                          rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    // one write port, one registered read port, read returns old data on collision
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* rtl/image_block_sum_binning.sv */
`timescale 1ns / 1ps
`default_nettype none

// Pixel binning by block sums.
// Pixels stream in on the s_ channel in column-major order (row index fastest),
// one signed fixed-point pixel per beat in s_tdata. Each bin_factor x bin_factor
// block is summed into one bin; edge blocks are partial. A bin leaves on the m_
// channel after its last pixel passes the update stage: m_tdata carries the sum,
// the bin row and the bin column, m_tlast marks the final bin of the image.
// The last pixel of a bin is registered in the update stage and its sum then in
// the output register, once that is free. Throughput: one pixel per cycle
// while the output is not stalled, set by the single read-modify-write of the
// accumulator RAM (one read, one write each cycle, with forwarding when
// consecutive pixels hit the same bin row).
// When the receiver stalls, one finished bin waits in the output register and
// the next pixel that closes a bin waits in the update stage; s_tready then
// drops until m_tready returns.
// Reset clears the position counters, empties the pipeline and loads the
// default factor and image size. The accumulator RAM needs no clearing: the
// first pixel of every bin overwrites its entry.
// Configuration must be written through cfg_wr_* only while the block is idle; the block does not enforce this.
module image_block_sum_binning #(
    parameter int MAX_ROWS   = ibsb_pkg::DEF_MAX_ROWS,
    parameter int MAX_FACTOR = ibsb_pkg::DEF_MAX_FACTOR,
    parameter int PIXEL_BITS = ibsb_pkg::DEF_PIXEL_BITS,
    localparam int ROW_W     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
    localparam int SUM_W     = PIXEL_BITS + 2 * $clog2(MAX_FACTOR),
    localparam int S_DATA_W  = ((PIXEL_BITS + 7) / 8) * 8,
    localparam int M_DATA_W  = ((SUM_W + ROW_W + ibsb_pkg::COLS_W + 7) / 8) * 8
) (
    input  wire                                aclk,
    input  wire                                aresetn,
    // configuration write port
    input  wire                                cfg_wr_en,
    input  wire [ibsb_pkg::CFG_INDEX_W-1:0]    cfg_wr_index,
    input  wire [ibsb_pkg::CFG_DATA_W-1:0]     cfg_wr_data,
    // pixel input
    input  wire                                s_tvalid,
    output logic                               s_tready,
    input  wire [S_DATA_W-1:0]                 s_tdata,   // pixel_value
    // bin output
    output logic                               m_tvalid,
    input  wire                                m_tready,
    output logic [M_DATA_W-1:0]                m_tdata,   // bin_sum, bin_row, bin_col
    output logic                               m_tlast    // last_bin
);

    localparam int PH_W  = (MAX_FACTOR > 1) ? $clog2(MAX_FACTOR) : 1;
    localparam int FW_A  = $clog2(MAX_FACTOR + 1);
    localparam int F_W   = (FW_A > ibsb_pkg::FACTOR_W) ? FW_A : ibsb_pkg::FACTOR_W;
    localparam int RW_A  = $clog2(MAX_ROWS + 1);
    localparam int R_W   = (RW_A > ibsb_pkg::ROWS_W) ? RW_A : ibsb_pkg::ROWS_W;
    localparam int C_W   = ibsb_pkg::COLS_W;

    // configuration registers
    logic [ibsb_pkg::FACTOR_W-1:0] factor_reg;
    logic [ibsb_pkg::ROWS_W-1:0]   rows_reg;
    logic [C_W-1:0]                cols_reg;

    // position state
    logic [ROW_W-1:0] row_cnt_reg, row_cnt_next;
    logic [C_W-1:0]   col_cnt_reg, col_cnt_next;
    logic [PH_W-1:0]  row_ph_reg, row_ph_next;
    logic [PH_W-1:0]  col_ph_reg, col_ph_next;
    logic [ROW_W-1:0] bin_row_reg, bin_row_next;
    logic [C_W-1:0]   bin_col_reg, bin_col_next;

    // update stage
    logic                          s1_valid_reg;
    logic signed [PIXEL_BITS-1:0]  s1_px_reg;
    logic                          s1_first_reg;
    logic                          s1_emit_reg;
    logic                          s1_last_reg;
    logic [ROW_W-1:0]              s1_idx_reg;
    logic [C_W-1:0]                s1_col_reg;
    logic                          fwd_hit_reg;
    logic [SUM_W-1:0]              fwd_sum_reg;

    // output register
    logic                          m_valid_reg;
    logic [SUM_W-1:0]              m_sum_reg;
    logic [ROW_W-1:0]              m_row_reg;
    logic [C_W-1:0]                m_col_reg;
    logic                          m_last_reg;

    logic             accept;
    logic             s1_adv;
    logic [F_W-1:0]   f_eff;
    logic [R_W-1:0]   rows_eff;
    logic [C_W-1:0]   cols_eff;
    logic             last_row, last_col, row_wrap, col_wrap, row_end, col_end;
    logic             first_px;
    logic [SUM_W-1:0] ram_rdata;
    logic [SUM_W-1:0] s1_base;
    logic [SUM_W-1:0] s1_sum;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            factor_reg <= ibsb_pkg::FACTOR_RST;
            rows_reg   <= ibsb_pkg::ROWS_RST;
            cols_reg   <= ibsb_pkg::COLS_RST;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                ibsb_pkg::CFG_BIN_FACTOR: factor_reg <= cfg_wr_data[ibsb_pkg::FACTOR_W-1:0];
                ibsb_pkg::CFG_IMAGE_ROWS: rows_reg   <= cfg_wr_data[ibsb_pkg::ROWS_W-1:0];
                ibsb_pkg::CFG_IMAGE_COLS: cols_reg   <= cfg_wr_data[C_W-1:0];
                default: ;
            endcase
        end
    end

    // clamp factor and image size to their legal ranges
    always_comb begin
        if (factor_reg == '0) begin
            f_eff = F_W'(1);
        end else if (F_W'(factor_reg) > F_W'(MAX_FACTOR)) begin
            f_eff = F_W'(MAX_FACTOR);
        end else begin
            f_eff = F_W'(factor_reg);
        end
        if (rows_reg == '0) begin
            rows_eff = R_W'(1);
        end else if (R_W'(rows_reg) > R_W'(MAX_ROWS)) begin
            rows_eff = R_W'(MAX_ROWS);
        end else begin
            rows_eff = R_W'(rows_reg);
        end
        cols_eff = (cols_reg == '0) ? C_W'(1) : cols_reg;
    end

    // block position of the current pixel
    always_comb begin
        last_row = (R_W'(row_cnt_reg) + R_W'(1)) >= rows_eff;
        last_col = ({1'b0, col_cnt_reg} + (C_W + 1)'(1)) >= {1'b0, cols_eff};
        row_wrap = (F_W'(row_ph_reg) + F_W'(1)) >= f_eff;
        col_wrap = (F_W'(col_ph_reg) + F_W'(1)) >= f_eff;
        row_end  = row_wrap || last_row;
        col_end  = col_wrap || last_col;
        first_px = (row_ph_reg == '0) && (col_ph_reg == '0);
    end

    // advance counters and phases
    always_comb begin
        row_cnt_next = row_cnt_reg;
        col_cnt_next = col_cnt_reg;
        row_ph_next  = row_ph_reg;
        col_ph_next  = col_ph_reg;
        bin_row_next = bin_row_reg;
        bin_col_next = bin_col_reg;
        if (last_row) begin
            row_cnt_next = '0;
            row_ph_next  = '0;
            bin_row_next = '0;
            if (last_col) begin
                col_cnt_next = '0;
                col_ph_next  = '0;
                bin_col_next = '0;
            end else begin
                col_cnt_next = col_cnt_reg + C_W'(1);
                if (col_wrap) begin
                    col_ph_next  = '0;
                    bin_col_next = bin_col_reg + C_W'(1);
                end else begin
                    col_ph_next = col_ph_reg + PH_W'(1);
                end
            end
        end else begin
            row_cnt_next = row_cnt_reg + ROW_W'(1);
            if (row_wrap) begin
                row_ph_next  = '0;
                bin_row_next = bin_row_reg + ROW_W'(1);
            end else begin
                row_ph_next = row_ph_reg + PH_W'(1);
            end
        end
    end

    // handshake: the update stage moves on unless its bin finds the output full and not draining
    assign s1_adv   = s1_valid_reg && (!s1_emit_reg || !m_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_adv;
    assign accept   = s_tvalid && s_tready;

    // accumulate: forward the previous write when it hits the same entry
    always_comb begin
        if (s1_first_reg) begin
            s1_base = '0;
        end else if (fwd_hit_reg) begin
            s1_base = fwd_sum_reg;
        end else begin
            s1_base = ram_rdata;
        end
        s1_sum = s1_base + {{(SUM_W - PIXEL_BITS){s1_px_reg[PIXEL_BITS-1]}}, s1_px_reg};
    end

    ibsb_ram #(
        .DATA_W (SUM_W),
        .DEPTH  (MAX_ROWS)
    ) u_acc_ram (
        .aclk    (aclk),
        .wr_en   (s1_adv),
        .wr_addr (s1_idx_reg),
        .wr_data (s1_sum),
        .rd_en   (accept),
        .rd_addr (bin_row_reg),
        .rd_data (ram_rdata)
    );

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_cnt_reg  <= '0;
            col_cnt_reg  <= '0;
            row_ph_reg   <= '0;
            col_ph_reg   <= '0;
            bin_row_reg  <= '0;
            bin_col_reg  <= '0;
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (accept) begin
                row_cnt_reg <= row_cnt_next;
                col_cnt_reg <= col_cnt_next;
                row_ph_reg  <= row_ph_next;
                col_ph_reg  <= col_ph_next;
                bin_row_reg <= bin_row_next;
                bin_col_reg <= bin_col_next;
            end
            if (accept) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_adv) begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv && s1_emit_reg) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload of the update stage
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_px_reg    <= s_tdata[PIXEL_BITS-1:0];
            s1_first_reg <= first_px;
            s1_emit_reg  <= row_end && col_end;
            s1_last_reg  <= last_row && last_col;
            s1_idx_reg   <= bin_row_reg;
            s1_col_reg   <= bin_col_reg;
            fwd_hit_reg  <= s1_valid_reg && (s1_idx_reg == bin_row_reg);
            fwd_sum_reg  <= s1_sum;
        end
    end

    // output beat payload
    always_ff @(posedge aclk) begin
        if (s1_adv && s1_emit_reg) begin
            m_sum_reg  <= s1_sum;
            m_row_reg  <= s1_idx_reg;
            m_col_reg  <= s1_col_reg;
            m_last_reg <= s1_last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_DATA_W'({m_col_reg, m_row_reg, m_sum_reg});
    assign m_tlast  = m_last_reg;

endmodule

`default_nettype wire
